// File: rtl/ptd_pkg.sv
// shared types, constants and codes of the periodic task dispatcher
// no dependencies; used by the interfaces, the slot table and the top level
package ptd_pkg;

  // slot table geometry
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // field widths
  localparam int ACTION_W = 3;
  localparam int ID_W     = 8;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 3;
  localparam int SLOTF_W  = 3;
  localparam int TICK_W   = 16;
  localparam int WDOG_W   = 15;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [WDOG_W-1:0] MAX_RUN_RESET = 15'd1000;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POLL   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DONE   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISPATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PASS     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd6;

  // one slot table entry
  typedef struct packed {
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] period;
    logic                enable;
    logic [TICK_W-1:0]   stamp;
  } entry_t;

  // table read and write ports
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

endpackage

// File: rtl/ptd_if.sv
// request and result channels of the periodic task dispatcher
// depends on ptd_pkg for field widths
interface ptd_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptd_pkg::ACTION_W-1:0]  action;
  logic [ptd_pkg::ID_W-1:0]      task_id;
  logic [ptd_pkg::PERIOD_W-1:0]  period;
  logic                          enable;

  modport source (output valid, action, task_id, period, enable, input ready);
  modport sink   (input valid, action, task_id, period, enable, output ready);
endinterface

interface ptd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptd_pkg::STATUS_W-1:0]  status;
  logic [ptd_pkg::SLOTF_W-1:0]   slot;
  logic [ptd_pkg::ID_W-1:0]      dispatched_id;

  modport source (output valid, status, slot, dispatched_id, input ready);
  modport sink   (input valid, status, slot, dispatched_id, output ready);
endinterface

// File: rtl/ptd_table.sv
// slot table memory: one read port with registered data, one write port
// depends on ptd_pkg; entries never written read back as zero
module ptd_table (
  input  logic             clk,
  input  logic             rst,
  input  ptd_pkg::rd_req_t rd,
  output ptd_pkg::entry_t  rd_data,
  input  ptd_pkg::wr_req_t wr
);

  ptd_pkg::entry_t              mem [ptd_pkg::SLOTS];
  logic [ptd_pkg::SLOTS-1:0]    written;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // per entry written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // registered read with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr.en && wr.addr == rd.addr) begin
        rd_data <= wr.data;
      end else if (written[rd.addr]) begin
        rd_data <= mem[rd.addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// File: rtl/periodic_task_dispatcher_unit.sv
// Periodic task dispatcher. A request is taken only while the block is idle; ready stays
// low until its result is registered, and the result register lets the next request in
// while a result still waits. Tick, unknown actions, requests while halted, done while
// idle and poll before the first tick go straight to the finish state. Busy, watchdog
// expiry and done first make one read of the slot table memory. Add, remove and poll
// sweep the table memory one slot per cycle from the start (poll from its cursor) and
// stop at the first match or after the last slot; an add into a free slot then needs
// one more read-modify-write step. A result held back by the receiver stalls the
// request after it. The watchdog register max_run_ticks sits at byte address 0 of the
// configuration port.
// depends on ptd_pkg, ptd_if (ptd_req_if, ptd_rsp_if) and ptd_table
module periodic_task_dispatcher_unit (
  input  logic                          clk,
  input  logic                          rst,
  ptd_req_if.sink                       req,
  ptd_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptd_pkg::PADDR_W-1:0]   paddr,
  input  logic [ptd_pkg::PDATA_W-1:0]   pwdata,
  output logic [ptd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_ADD_WR  = 3'd2;
  localparam logic [2:0] S_RUN_USE = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  localparam logic [ptd_pkg::CNT_W-1:0] SCAN_END = ptd_pkg::CNT_W'(ptd_pkg::SLOTS);
  localparam logic [ptd_pkg::SLOT_W-1:0] LAST_SLOT = ptd_pkg::SLOT_W'(ptd_pkg::SLOTS - 1);

  logic [2:0]                       state;
  logic [ptd_pkg::ACTION_W-1:0]     act;
  logic [ptd_pkg::ID_W-1:0]         cmd_id;
  logic [ptd_pkg::PERIOD_W-1:0]     cmd_period;
  logic                             cmd_enable;
  logic [ptd_pkg::CNT_W-1:0]        iss;
  logic                             rvalid;
  logic [ptd_pkg::SLOT_W-1:0]       ridx;
  logic [ptd_pkg::SLOT_W-1:0]       add_idx;
  logic [ptd_pkg::SLOTS-1:0]        slot_valid;
  logic [ptd_pkg::TICK_W-1:0]       tick_count;
  logic                             tick_seen;
  logic                             running;
  logic [ptd_pkg::SLOT_W-1:0]       running_slot;
  logic [ptd_pkg::WDOG_W-1:0]       watchdog_left;
  logic [ptd_pkg::SLOT_W-1:0]       scan_cursor;
  logic                             halted;
  logic [ptd_pkg::WDOG_W-1:0]       max_run_ticks;
  logic [ptd_pkg::STATUS_W-1:0]     res_status;
  logic [ptd_pkg::SLOTF_W-1:0]      res_slot;
  logic [ptd_pkg::ID_W-1:0]         res_id;
  logic                             out_valid;
  logic [ptd_pkg::STATUS_W-1:0]     out_status;
  logic [ptd_pkg::SLOTF_W-1:0]      out_slot;
  logic [ptd_pkg::ID_W-1:0]         out_id;

  ptd_pkg::rd_req_t                 rd;
  ptd_pkg::wr_req_t                 wr;
  ptd_pkg::entry_t                  ent;

  logic                             accept;
  logic [ptd_pkg::WDOG_W-1:0]       wd_dec;
  logic                             go_run;
  logic [ptd_pkg::TICK_W-1:0]       elapsed;
  logic                             hit;
  logic                             scan_issue;
  logic                             scan_end;
  logic                             free_any;
  logic [ptd_pkg::SLOT_W-1:0]       free_idx;
  logic                             cfg_wr;

  ptd_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .rd_data (ent),
    .wr      (wr)
  );

  // channel handshakes
  assign req.ready         = (state == S_IDLE);
  assign accept            = req.valid && req.ready;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.slot          = out_slot;
  assign rsp.dispatched_id = out_id;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : ptd_pkg::PDATA_W'(max_run_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_ticks <= ptd_pkg::MAX_RUN_RESET;
    end else if (cfg_wr) begin
      max_run_ticks <= pwdata[ptd_pkg::WDOG_W-1:0];
    end
  end

  // first free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ptd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = ptd_pkg::SLOT_W'(i);
      end
    end
  end

  // requests that need the running slot's entry
  assign wd_dec = watchdog_left - 1'b1;
  always_comb begin
    go_run = 1'b0;
    if (accept && !halted) begin
      case (req.action)
        ptd_pkg::ACT_TICK: go_run = running && (wd_dec == '0);
        ptd_pkg::ACT_POLL: go_run = tick_seen && running;
        ptd_pkg::ACT_DONE: go_run = running;
        default:           go_run = 1'b0;
      endcase
    end
  end

  // scan compare on the registered table read
  assign elapsed = tick_count - ent.stamp;
  always_comb begin
    if (act == ptd_pkg::ACT_POLL) begin
      hit = rvalid && slot_valid[ridx] && ent.enable && (elapsed > ent.period);
    end else begin
      hit = rvalid && slot_valid[ridx] && (ent.task_id == cmd_id);
    end
  end

  assign scan_issue = (state == S_SCAN) && !hit && (iss < SCAN_END);
  assign scan_end   = (state == S_SCAN) && !rvalid && (iss == SCAN_END);

  // table read selection
  always_comb begin
    rd.en   = 1'b0;
    rd.addr = running_slot;
    if (go_run) begin
      rd.en   = 1'b1;
    end else if (scan_issue) begin
      rd.en   = 1'b1;
      rd.addr = iss[ptd_pkg::SLOT_W-1:0];
    end else if (scan_end && act == ptd_pkg::ACT_ADD && free_any) begin
      rd.en   = 1'b1;
      rd.addr = free_idx;
    end
  end

  // table write selection
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = ridx;
    wr.data = ent;
    if (state == S_SCAN && hit && act == ptd_pkg::ACT_ADD) begin
      wr.en          = 1'b1;
      wr.data.period = cmd_period;
      wr.data.enable = cmd_enable;
    end else if (state == S_ADD_WR) begin
      wr.en           = 1'b1;
      wr.addr         = add_idx;
      wr.data.task_id = cmd_id;
      wr.data.period  = cmd_period;
      wr.data.enable  = cmd_enable;
    end else if (state == S_RUN_USE && act == ptd_pkg::ACT_DONE) begin
      wr.en         = 1'b1;
      wr.addr       = running_slot;
      wr.data.stamp = tick_count;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rvalid        <= 1'b0;
      slot_valid    <= '0;
      tick_count    <= '0;
      tick_seen     <= 1'b0;
      running       <= 1'b0;
      running_slot  <= '0;
      watchdog_left <= '0;
      scan_cursor   <= '0;
      halted        <= 1'b0;
    end else begin
      rvalid <= scan_issue;
      if (scan_issue) begin
        ridx <= iss[ptd_pkg::SLOT_W-1:0];
        iss  <= iss + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act        <= req.action;
            cmd_id     <= req.task_id;
            cmd_period <= req.period;
            cmd_enable <= req.enable;
            res_slot   <= '0;
            res_id     <= '0;
            if (halted) begin
              res_status <= ptd_pkg::ST_HALTED;
              state      <= S_FIN;
            end else begin
              case (req.action)
                ptd_pkg::ACT_ADD, ptd_pkg::ACT_REMOVE: begin
                  iss   <= '0;
                  state <= S_SCAN;
                end
                ptd_pkg::ACT_TICK: begin
                  tick_count <= tick_count + 1'b1;
                  tick_seen  <= 1'b1;
                  res_status <= ptd_pkg::ST_OK;
                  if (running) begin
                    watchdog_left <= wd_dec;
                  end
                  if (running && wd_dec == '0) begin
                    halted  <= 1'b1;
                    running <= 1'b0;
                    state   <= S_RUN_USE;
                  end else begin
                    state <= S_FIN;
                  end
                end
                ptd_pkg::ACT_POLL: begin
                  if (!tick_seen) begin
                    res_status <= ptd_pkg::ST_PASS;
                    state      <= S_FIN;
                  end else if (running) begin
                    state <= S_RUN_USE;
                  end else begin
                    iss   <= ptd_pkg::CNT_W'(scan_cursor);
                    state <= S_SCAN;
                  end
                end
                ptd_pkg::ACT_DONE: begin
                  if (running) begin
                    state <= S_RUN_USE;
                  end else begin
                    res_status <= ptd_pkg::ST_ERROR;
                    state      <= S_FIN;
                  end
                end
                default: begin
                  res_status <= ptd_pkg::ST_ERROR;
                  state      <= S_FIN;
                end
              endcase
            end
          end
        end

        // sweep the table one slot per cycle
        S_SCAN: begin
          if (hit) begin
            state    <= S_FIN;
            res_slot <= ptd_pkg::SLOTF_W'(ridx);
            if (act == ptd_pkg::ACT_POLL) begin
              running       <= 1'b1;
              running_slot  <= ridx;
              watchdog_left <= max_run_ticks;
              scan_cursor   <= (ridx == LAST_SLOT) ? '0 : ridx + 1'b1;
              res_status    <= ptd_pkg::ST_DISPATCH;
              res_id        <= ent.task_id;
            end else begin
              res_status <= ptd_pkg::ST_OK;
              res_id     <= cmd_id;
              if (act == ptd_pkg::ACT_REMOVE) begin
                slot_valid[ridx] <= 1'b0;
              end
            end
          end else if (scan_end) begin
            if (act == ptd_pkg::ACT_POLL) begin
              scan_cursor <= '0;
              res_status  <= ptd_pkg::ST_PASS;
              res_slot    <= '0;
              res_id      <= '0;
              state       <= S_FIN;
            end else if (act == ptd_pkg::ACT_ADD && free_any) begin
              add_idx <= free_idx;
              state   <= S_ADD_WR;
            end else begin
              res_status <= ptd_pkg::ST_ERROR;
              res_slot   <= '0;
              res_id     <= cmd_id;
              state      <= S_FIN;
            end
          end
        end

        // insert into the free slot, keeping its stamp
        S_ADD_WR: begin
          slot_valid[add_idx] <= 1'b1;
          res_status          <= ptd_pkg::ST_OK;
          res_slot            <= ptd_pkg::SLOTF_W'(add_idx);
          res_id              <= cmd_id;
          state               <= S_FIN;
        end

        // running slot entry is now on the read port
        S_RUN_USE: begin
          res_slot <= ptd_pkg::SLOTF_W'(running_slot);
          res_id   <= ent.task_id;
          state    <= S_FIN;
          case (act)
            ptd_pkg::ACT_POLL: res_status <= ptd_pkg::ST_BUSY;
            ptd_pkg::ACT_TICK: res_status <= ptd_pkg::ST_EXPIRED;
            ptd_pkg::ACT_DONE: begin
              running    <= 1'b0;
              res_status <= ptd_pkg::ST_OK;
            end
            default: res_status <= ptd_pkg::ST_ERROR;
          endcase
        end

        // hand the result to the output register
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_slot   <= res_slot;
      out_id     <= res_id;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
